@@ rtl/bts_pkg.sv @@
// shared types, codes and constants of the bilinear texture sampler
package bts_pkg;

    // request and result codes
    localparam logic       REQ_LOAD     = 1'b0;
    localparam logic       REQ_SAMPLE   = 1'b1;
    localparam logic [1:0] KIND_SAMPLE  = 2'd0;
    localparam logic [1:0] KIND_DONE    = 2'd1;
    localparam logic [1:0] KIND_REFUSED = 2'd2;

    // configuration port
    localparam int         CFG_IDX_W      = 2;
    localparam int         CFG_DATA_W     = 13;
    localparam logic [1:0] CFG_MAP_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_MAP_HEIGHT = 2'd1;

    // fixed field widths
    localparam int DIM_W   = 13;
    localparam int PROD_W  = 2 * DIM_W;
    localparam int UV_W    = 17;
    localparam int LEVEL_W = 16;

    localparam logic [15:0] FULL_LEVEL = 16'hFF00;
    localparam logic [63:0] FNV_BASIS  = 64'hCBF29CE484222325;

    // sequencer counter limits
    localparam logic [2:0] LAST_BYTE = 3'd3;
    localparam logic [2:0] LAST_TAP  = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MIX,
        S_FOLD,
        S_FULL,
        S_COORD,
        S_ADDR,
        S_READ,
        S_ROW,
        S_COL
    } t_state;

    typedef struct packed {
        logic       accept;
        logic       mix;
        logic [1:0] byte_sel;
        logic       load_fin;
        logic       full_emit;
        logic       coord;
        logic       addr;
        logic       rd;
        logic [1:0] rd_sel;
        logic       cap;
        logic [1:0] cap_sel;
        logic       row;
        logic       col_emit;
    } t_cmd;

    typedef struct packed {
        logic in_req_type;
        logic last;
        logic map_valid;
        logic out_free;
    } t_sts;

    // one fnv-1a step, multiply by the 64-bit prime 2^40 + 0x1b3 as shifts
    function automatic logic [63:0] fnv_mix(input logic [63:0] h, input logic [63:0] v);
        logic [63:0] x;
        x = h ^ v;
        return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
    endfunction

endpackage

@@ rtl/bts_if.sv @@
// request and result channel interfaces of the texture sampler
interface bts_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [31:0] texel_rgba;
    logic        texel_last;
    logic [16:0] sample_u;
    logic [16:0] sample_v;

    modport source (
        output valid, req_type, texel_rgba, texel_last, sample_u, sample_v,
        input  ready
    );
    modport sink (
        input  valid, req_type, texel_rgba, texel_last, sample_u, sample_v,
        output ready
    );
endinterface

interface bts_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [15:0] red_level;
    logic [15:0] green_level;
    logic [15:0] blue_level;
    logic [63:0] content_hash;

    modport source (
        output valid, result_kind, red_level, green_level, blue_level, content_hash,
        input  ready
    );
    modport sink (
        input  valid, result_kind, red_level, green_level, blue_level, content_hash,
        output ready
    );
endinterface

@@ rtl/bts_ctrl.sv @@
// sequencer of the texture sampler: load hashing, sample reads and result hand-off
module bts_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  bts_pkg::t_sts i_sts,
    output bts_pkg::t_cmd o_cmd
);
    import bts_pkg::*;

    t_state     r_state, n_state;
    logic [2:0] r_cnt, n_cnt;
    logic       accept;

    assign accept = i_in_valid && (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= 3'd0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = 3'd0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_sts.in_req_type == REQ_LOAD) begin
                        n_state = S_MIX;
                    end else if (i_sts.map_valid) begin
                        n_state = S_COORD;
                    end else begin
                        n_state = S_FULL;
                    end
                end
            end
            S_MIX: begin
                if (r_cnt == LAST_BYTE) begin
                    n_state = i_sts.last ? S_FOLD : S_IDLE;
                end else begin
                    n_cnt = r_cnt + 3'd1;
                end
            end
            S_FOLD: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            S_FULL: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            S_COORD: n_state = S_ADDR;
            S_ADDR:  n_state = S_READ;
            S_READ: begin
                if (r_cnt == LAST_TAP) begin
                    n_state = S_ROW;
                end else begin
                    n_cnt = r_cnt + 3'd1;
                end
            end
            S_ROW: n_state = S_COL;
            S_COL: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready      = (r_state == S_IDLE);
        o_cmd           = '0;
        o_cmd.accept    = accept;
        o_cmd.byte_sel  = r_cnt[1:0];
        o_cmd.rd_sel    = r_cnt[1:0];
        o_cmd.cap_sel   = 2'(r_cnt - 3'd1);
        case (r_state)
            S_MIX:   o_cmd.mix       = 1'b1;
            S_FOLD:  o_cmd.load_fin  = i_sts.out_free;
            S_FULL:  o_cmd.full_emit = i_sts.out_free;
            S_COORD: o_cmd.coord     = 1'b1;
            S_ADDR:  o_cmd.addr      = 1'b1;
            S_READ: begin
                o_cmd.rd  = (r_cnt != LAST_TAP);
                o_cmd.cap = (r_cnt != 3'd0);
            end
            S_ROW:   o_cmd.row       = 1'b1;
            S_COL:   o_cmd.col_emit  = i_sts.out_free;
            default: o_cmd.rd        = 1'b0;
        endcase
    end

    a_load_starts_mix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_sts.in_req_type == REQ_LOAD |=> r_state == S_MIX && r_cnt == 3'd0)
        else $error("load item did not start the hash sequence");

    a_no_map_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_sts.in_req_type == REQ_SAMPLE && !i_sts.map_valid |=> r_state == S_FULL)
        else $error("sample without a map did not go to full level");

    a_read_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_READ |-> r_cnt <= LAST_TAP)
        else $error("tap counter overran");

    a_row_after_taps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_ROW |-> $past(r_state) == S_READ && $past(r_cnt) == LAST_TAP)
        else $error("row mix started before all four taps were read");

endmodule

@@ rtl/bts_datapath.sv @@
// texel store, hash, coordinate, address and interpolation datapath
module bts_datapath #(
    parameter int MAX_TEXELS   = 4096,
    parameter int UV_FRAC_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bts_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bts_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_req_type,
    input  logic [31:0]                    i_texel_rgba,
    input  logic                           i_texel_last,
    input  logic [16:0]                    i_sample_u,
    input  logic [16:0]                    i_sample_v,
    input  bts_pkg::t_cmd                  i_cmd,
    output bts_pkg::t_sts                  o_sts,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [1:0]                     o_result_kind,
    output logic [15:0]                    o_red_level,
    output logic [15:0]                    o_green_level,
    output logic [15:0]                    o_blue_level,
    output logic [63:0]                    o_content_hash
);
    import bts_pkg::*;

    localparam int F   = UV_FRAC_BITS;
    localparam int FW  = F + 1;
    localparam int UW  = (F + 1 > UV_W) ? F + 1 : UV_W;
    localparam int FXW = F + 1 + DIM_W;
    localparam int SW  = F + 9;
    localparam int SEW = SW + 8;
    localparam int CSW = F + 17;
    localparam int AW  = (MAX_TEXELS > 1) ? $clog2(MAX_TEXELS) : 1;
    localparam int CW  = $clog2(MAX_TEXELS + 2);
    localparam logic [UW-1:0] UV_ONE = UW'(1) << F;
    localparam logic [FW-1:0] ONE_F  = FW'(1) << F;
    localparam logic [CW-1:0] CAP    = CW'(MAX_TEXELS);

    // control state
    logic [DIM_W-1:0]  r_w, r_h;
    logic [PROD_W-1:0] r_need;
    logic [CW-1:0]     r_count;
    logic [63:0]       r_hash;
    logic              r_map_valid;
    logic              r_o_valid;

    // payload registers
    logic [31:0]       r_rgba;
    logic              r_last;
    logic [UV_W-1:0]   r_u, r_v;
    logic [FXW-1:0]    r_fx, r_fy;
    logic [DIM_W-1:0]  r_x0, r_x1;
    logic [F-1:0]      r_tx, r_ty;
    logic [PROD_W-1:0] r_b0, r_b1;
    logic [31:0]       r_rd_data;
    logic [31:0]       r_tex [4];
    logic [15:0]       r_top [3];
    logic [15:0]       r_bot [3];
    logic [1:0]        r_kind;
    logic [15:0]       r_lvl [3];
    logic [63:0]       r_o_hash;

    logic [31:0]       r_mem [MAX_TEXELS];

    logic              load_ok;
    logic              st_we;
    logic [UW-1:0]     cu, cv;
    logic [DIM_W-1:0]  w1, h1, x0, y0, y1;
    logic [PROD_W-1:0] rd_addr;
    logic [63:0]       fold_val;
    logic [15:0]       n_top [3];
    logic [15:0]       n_bot [3];
    logic [15:0]       n_lvl [3];

    assign w1 = r_w - DIM_W'(1);
    assign h1 = r_h - DIM_W'(1);

    assign load_ok = (r_w != '0) && (r_h != '0) && (r_count <= CAP) &&
                     (PROD_W'(r_count) == r_need);
    assign fold_val = {19'd0, r_w, 19'd0, r_h};
    assign st_we    = i_cmd.accept && (i_req_type == REQ_LOAD) && (r_count < CAP);

    always_comb begin
        cu = (UW'(r_u) > UV_ONE) ? UV_ONE : UW'(r_u);
        cv = (UW'(r_v) > UV_ONE) ? UV_ONE : UW'(r_v);
        x0 = r_fx[F +: DIM_W];
        y0 = r_fy[F +: DIM_W];
        y1 = (y0 == h1) ? y0 : y0 + DIM_W'(1);
        rd_addr = (i_cmd.rd_sel[1] ? r_b1 : r_b0) +
                  PROD_W'(i_cmd.rd_sel[0] ? r_x1 : r_x0);
    end

    // bilinear mix, one lane per color channel
    always_comb begin
        logic [SW-1:0]  s_top, s_bot;
        logic [SEW-1:0] e_top, e_bot;
        logic [CSW-1:0] c_sum;
        logic [FW-1:0]  wtx, wty;
        wtx = ONE_F - FW'(r_tx);
        wty = ONE_F - FW'(r_ty);
        for (int k = 0; k < 3; k++) begin
            s_top = SW'(r_tex[0][31 - 8 * k -: 8]) * SW'(wtx) +
                    SW'(r_tex[1][31 - 8 * k -: 8]) * SW'(r_tx);
            s_bot = SW'(r_tex[2][31 - 8 * k -: 8]) * SW'(wtx) +
                    SW'(r_tex[3][31 - 8 * k -: 8]) * SW'(r_tx);
            e_top = {s_top, 8'd0};
            e_bot = {s_bot, 8'd0};
            n_top[k] = e_top[F +: 16];
            n_bot[k] = e_bot[F +: 16];
            c_sum = CSW'(r_top[k]) * CSW'(wty) + CSW'(r_bot[k]) * CSW'(r_ty);
            n_lvl[k] = c_sum[F +: 16];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w         <= DIM_W'(1);
            r_h         <= DIM_W'(1);
            r_count     <= '0;
            r_hash      <= FNV_BASIS;
            r_map_valid <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MAP_WIDTH: begin
                        r_w         <= i_cfg_data;
                        r_map_valid <= 1'b0;
                    end
                    CFG_MAP_HEIGHT: begin
                        r_h         <= i_cfg_data;
                        r_map_valid <= 1'b0;
                    end
                    default: r_map_valid <= r_map_valid;
                endcase
            end
            if (i_cmd.accept && i_req_type == REQ_LOAD) begin
                r_map_valid <= 1'b0;
                if (r_count <= CAP) r_count <= r_count + CW'(1);
            end
            if (i_cmd.mix) begin
                r_hash <= fnv_mix(r_hash, 64'(r_rgba[{~i_cmd.byte_sel, 3'b000} +: 8]));
            end
            if (i_cmd.load_fin) begin
                r_count <= '0;
                r_hash  <= FNV_BASIS;
                if (load_ok) r_map_valid <= 1'b1;
            end
            if (i_cmd.load_fin || i_cmd.full_emit || i_cmd.col_emit) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // payload path
    always_ff @(posedge i_clk) begin
        r_need <= PROD_W'(r_w) * PROD_W'(r_h);
        if (i_cmd.accept) begin
            r_rgba <= i_texel_rgba;
            r_last <= i_texel_last;
            r_u    <= i_sample_u;
            r_v    <= i_sample_v;
        end
        if (i_cmd.coord) begin
            r_fx <= FXW'(cu[F:0]) * FXW'(w1);
            r_fy <= FXW'(cv[F:0]) * FXW'(h1);
        end
        if (i_cmd.addr) begin
            r_x0 <= x0;
            r_x1 <= (x0 == w1) ? x0 : x0 + DIM_W'(1);
            r_tx <= r_fx[F-1:0];
            r_ty <= r_fy[F-1:0];
            r_b0 <= PROD_W'(y0) * PROD_W'(r_w);
            r_b1 <= PROD_W'(y1) * PROD_W'(r_w);
        end
        if (i_cmd.cap) r_tex[i_cmd.cap_sel] <= r_rd_data;
        if (i_cmd.row) begin
            r_top <= n_top;
            r_bot <= n_bot;
        end
        if (i_cmd.load_fin) begin
            r_kind   <= load_ok ? KIND_DONE : KIND_REFUSED;
            r_lvl    <= '{16'd0, 16'd0, 16'd0};
            r_o_hash <= load_ok ? fnv_mix(r_hash, fold_val) : 64'd0;
        end
        if (i_cmd.full_emit) begin
            r_kind   <= KIND_SAMPLE;
            r_lvl    <= '{FULL_LEVEL, FULL_LEVEL, FULL_LEVEL};
            r_o_hash <= 64'd0;
        end
        if (i_cmd.col_emit) begin
            r_kind   <= KIND_SAMPLE;
            r_lvl    <= n_lvl;
            r_o_hash <= 64'd0;
        end
    end

    // texel store, one port
    always_ff @(posedge i_clk) begin
        if (st_we) r_mem[r_count[AW-1:0]] <= i_texel_rgba;
        if (i_cmd.rd) r_rd_data <= r_mem[rd_addr[AW-1:0]];
    end

    assign o_sts.in_req_type = i_req_type;
    assign o_sts.last        = r_last;
    assign o_sts.map_valid   = r_map_valid;
    assign o_sts.out_free    = !r_o_valid || i_out_ready;

    assign o_out_valid    = r_o_valid;
    assign o_result_kind  = r_kind;
    assign o_red_level    = r_lvl[0];
    assign o_green_level  = r_lvl[1];
    assign o_blue_level   = r_lvl[2];
    assign o_content_hash = r_o_hash;

endmodule

@@ rtl/bilinear_texture_sampler_core.sv @@
// top level of the bilinear texture sampler: sequencer plus datapath
// An RGBA8 map is loaded one texel per item in raster order while a 64-bit
// FNV-1a hash runs over its bytes; the last texel folds in the dimensions and
// returns the hash, or refuses the load if the count is not width*height or
// exceeds MAX_TEXELS. A sample item clamps u,v to [0,1], scales them by
// size-1 and mixes the four clamp-to-edge neighbors into 8.8 red, green and
// blue levels; without a valid map it returns full scale. A load texel
// occupies the block while the hash takes one byte a cycle, the last texel
// also waits for a free result register; a sample occupies it for the
// coordinate and address stages, the four reads through the single store
// port and two mixing stages; a sample without a map only waits for the
// result register. The result sits in an output register so the next item
// is taken while a result still waits. Width or height writes clear the map.
module bilinear_texture_sampler_core #(
    parameter int MAX_TEXELS   = 4096,
    parameter int UV_FRAC_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bts_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bts_pkg::CFG_DATA_W-1:0] i_cfg_data,
    bts_req_if.sink                        i_req,
    bts_rsp_if.source                      o_rsp
);
    import bts_pkg::*;

    // command and status between sequencer and datapath
    t_cmd cmd;
    t_sts sts;

    bts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    bts_datapath #(
        .MAX_TEXELS   (MAX_TEXELS),
        .UV_FRAC_BITS (UV_FRAC_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_req_type     (i_req.req_type),
        .i_texel_rgba   (i_req.texel_rgba),
        .i_texel_last   (i_req.texel_last),
        .i_sample_u     (i_req.sample_u),
        .i_sample_v     (i_req.sample_v),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_out_valid    (o_rsp.valid),
        .i_out_ready    (o_rsp.ready),
        .o_result_kind  (o_rsp.result_kind),
        .o_red_level    (o_rsp.red_level),
        .o_green_level  (o_rsp.green_level),
        .o_blue_level   (o_rsp.blue_level),
        .o_content_hash (o_rsp.content_hash)
    );

endmodule
